// ===== sv/rcp_pkg.sv =====
// Shared constants, types and controller-datapath interface for the chunk pool byte FIFO.
package rcp_pkg;

  localparam int unsigned PoolBlocksDef = 32;
  localparam int unsigned BlockBytesDef = 256;
  localparam int unsigned RingSlotsDef  = 32;
  localparam int unsigned ChunkW        = 9;

  localparam logic ActWrite = 1'b0;
  localparam logic ActRead  = 1'b1;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRead  = 3'b010,
    StOut   = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_write;
    logic start_read;
    logic finish_read;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic act;
  } dp_sts_t;

endpackage

// ===== sv/rx_chunk_pool_byte_fifo_unit.sv =====
// Top level of the chunk pool byte FIFO.
// A write item passes from acceptance through StOut into the output registers; a read first
// passes through StRead for the registered store read. The input stalls until the result is
// loaded, so no new item is taken before the last one's result is loaded; an output stall holds it.
// Reset is asynchronous, active low: all blocks free, ring empty, chunk size maximum.
// Store, lengths and ring contents are not cleared; free stack reads as its reset order.
module rx_chunk_pool_byte_fifo_unit
  import rcp_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = PoolBlocksDef,
  parameter int unsigned BLOCK_BYTES = BlockBytesDef,
  parameter int unsigned RING_SLOTS  = RingSlotsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [7:0]                       write_byte_i,
  input  logic                             message_last_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ChunkW-1:0]                cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             accepted_o,
  output logic [7:0]                       read_byte_o,
  output logic                             read_valid_o,
  output logic [15:0]                      pushed_count_o,
  output logic                             message_done_o,
  output logic [$clog2(POOL_BLOCKS+1)-1:0] free_blocks_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rcp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rcp_dpath #(
    .POOL_BLOCKS(POOL_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES), .RING_SLOTS(RING_SLOTS)
  ) u_dpath (
    .clk_i, .rst_ni, .action_i, .write_byte_i, .message_last_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .accepted_o, .read_byte_o, .read_valid_o, .pushed_count_o,
    .message_done_o, .free_blocks_o
  );

`ifndef ASSERT_OFF
  // A result never reports both a stored write byte and a delivered read byte.
  a_acc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && read_valid_o)) else $error("acc and read both set");
  // The free count never exceeds the pool.
  a_free_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(free_blocks_o) <= POOL_BLOCKS)) else $error("free count overflow");
  // An accepted item stalls the input in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");
`endif

endmodule

// ===== sv/rcp_ctrl.sv =====
// Controller state machine of the chunk pool byte FIFO.
module rcp_ctrl
  import rcp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.act == ActRead) begin
            cmd_o.start_read = 1'b1;
            state_d = StRead;
          end else begin
            cmd_o.start_write = 1'b1;
            state_d = StOut;
          end
        end
      end
      StRead: begin
        // The store read data is now registered.
        cmd_o.finish_read = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/rcp_dpath.sv =====
// Datapath of the chunk pool byte FIFO: block store, free stack, ready ring and counters.
module rcp_dpath
  import rcp_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = PoolBlocksDef,
  parameter int unsigned BLOCK_BYTES = BlockBytesDef,
  parameter int unsigned RING_SLOTS  = RingSlotsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              action_i,
  input  logic [7:0]                        write_byte_i,
  input  logic                              message_last_i,
  input  logic                              cfg_we_i,
  input  logic [ChunkW-1:0]                 cfg_data_i,
  input  dp_cmd_t                           cmd_i,
  output dp_sts_t                           sts_o,
  output logic                              accepted_o,
  output logic [7:0]                        read_byte_o,
  output logic                              read_valid_o,
  output logic [15:0]                       pushed_count_o,
  output logic                              message_done_o,
  output logic [$clog2(POOL_BLOCKS+1)-1:0]  free_blocks_o
);

  localparam int unsigned BlkW = $clog2(POOL_BLOCKS);
  localparam int unsigned PosW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int unsigned LenW = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned RngW = $clog2(RING_SLOTS);
  localparam int unsigned CntW = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned AddrW = BlkW + PosW;

  logic [7:0]      store_mem [POOL_BLOCKS << PosW];
  logic [LenW-1:0] len_mem   [POOL_BLOCKS];
  logic [BlkW-1:0] free_mem  [POOL_BLOCKS];
  logic [BlkW-1:0] ring_mem  [RING_SLOTS];

  logic [CntW-1:0] free_cnt_q;
  logic [RngW-1:0] head_q, tail_q;
  logic [BlkW-1:0] rd_blk_q, fill_blk_q;
  logic            rd_act_q, fill_act_q, drop_q;
  logic [LenW-1:0] rd_pos_q, fill_cnt_q;
  logic [15:0]     msg_q;
  logic [ChunkW-1:0] chunk_q;
  logic [LenW-1:0] rd_len_q;
  logic [7:0]      rd_data_q;
  logic            rd_hit_q;

  // Pending result fields.
  logic acc_q, done_q;
  logic [15:0] push_q;

  logic [LenW-1:0] eff_chunk;
  always_comb begin
    if (chunk_q == '0 || 32'(chunk_q) > BLOCK_BYTES) eff_chunk = LenW'(BLOCK_BYTES);
    else eff_chunk = LenW'(chunk_q);
  end

  assign sts_o.act = action_i;

  // Free stack entries that were never written read as their reset values; a flag
  // marks the entries that have been written.
  logic [POOL_BLOCKS-1:0] free_wr_q;
  function automatic logic [BlkW-1:0] free_rd(input logic [BlkW-1:0] idx,
                                              input logic wr,
                                              input logic [BlkW-1:0] val);
    if (wr) return val;
    return BlkW'(POOL_BLOCKS - 1) - idx;
  endfunction

  // Write path combinational decisions.
  logic [CntW-1:0] wfree;
  logic            w_fill, w_drop, w_acc, w_cmp, w_push, w_ret, w_ret_ok;
  logic [BlkW-1:0] w_blk, pop_idx;
  logic [LenW-1:0] w_pos, w_cnt;
  logic [RngW-1:0] tail_nx;
  logic [16:0]     msg_sum;
  logic [15:0]     msg_sat;
  always_comb begin
    pop_idx = BlkW'(free_cnt_q - 1'b1);
    wfree   = free_cnt_q;
    w_fill  = fill_act_q;
    w_drop  = drop_q;
    w_blk   = fill_blk_q;
    w_pos   = fill_cnt_q;
    if (!drop_q && !fill_act_q) begin
      if (free_cnt_q == '0) w_drop = 1'b1;
      else begin
        wfree  = free_cnt_q - 1'b1;
        w_blk  = free_rd(pop_idx, free_wr_q[pop_idx], free_mem[pop_idx]);
        w_pos  = '0;
        w_fill = 1'b1;
      end
    end
    w_acc    = !w_drop && w_fill;
    w_cnt    = w_pos + 1'b1;
    w_cmp    = w_acc && (w_cnt >= eff_chunk || message_last_i);
    tail_nx  = (32'(tail_q) == RING_SLOTS - 1) ? '0 : tail_q + 1'b1;
    w_push   = w_cmp && (tail_nx != head_q);
    w_ret    = w_cmp && !w_push;
    w_ret_ok = w_ret && (32'(wfree) < POOL_BLOCKS);
    msg_sum  = {1'b0, msg_q} + 17'(w_cnt);
    msg_sat  = msg_sum[16] ? 16'hFFFF : msg_sum[15:0];
  end

  logic [BlkW-1:0] r_blk;
  assign r_blk = ring_mem[head_q];
  logic            r_new;
  assign r_new = !rd_act_q && (head_q != tail_q);
  logic [BlkW-1:0] r_cur;
  assign r_cur = r_new ? r_blk : rd_blk_q;
  logic [LenW-1:0] r_pos;
  assign r_pos = r_new ? '0 : rd_pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_write && w_acc)
      store_mem[AddrW'({w_blk, PosW'(w_pos)})] <= write_byte_i;
    if (cmd_i.start_write && w_push) begin
      len_mem[w_blk]   <= w_cnt;
      ring_mem[tail_q] <= w_blk;
    end
    if (cmd_i.start_write && w_ret_ok)
      free_mem[BlkW'(wfree)] <= w_blk;
    if (cmd_i.finish_read && rd_hit_q && (rd_pos_q >= rd_len_q)
        && 32'(free_cnt_q) < POOL_BLOCKS)
      free_mem[BlkW'(free_cnt_q)] <= rd_blk_q;
    if (cmd_i.start_read) begin
      rd_data_q <= store_mem[AddrW'({r_cur, PosW'(r_pos)})];
      rd_len_q  <= len_mem[r_cur];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= CntW'(POOL_BLOCKS);
      free_wr_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      rd_blk_q   <= '0;
      rd_act_q   <= 1'b0;
      rd_pos_q   <= '0;
      fill_blk_q <= '0;
      fill_cnt_q <= '0;
      fill_act_q <= 1'b0;
      drop_q     <= 1'b0;
      msg_q      <= '0;
      chunk_q    <= ChunkW'(BLOCK_BYTES);
      rd_hit_q   <= 1'b0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      push_q     <= '0;
    end else begin
      if (cfg_we_i) chunk_q <= cfg_data_i;
      if (cmd_i.start_write) begin
        rd_hit_q   <= 1'b0;
        acc_q      <= w_acc;
        free_cnt_q <= w_ret_ok ? wfree + 1'b1 : wfree;
        if (w_ret_ok) free_wr_q[BlkW'(wfree)] <= 1'b1;
        fill_blk_q <= w_blk;
        fill_act_q <= w_fill && !w_cmp;
        fill_cnt_q <= w_cmp ? '0 : (w_acc ? w_cnt : w_pos);
        // The last byte of a message always ends the drop mode.
        drop_q     <= (w_drop || w_ret) && !message_last_i;
        if (w_push) tail_q <= tail_nx;
        if (message_last_i) msg_q <= '0;
        else if (w_push) msg_q <= msg_sat;
        push_q <= w_push ? msg_sat : msg_q;
        done_q <= message_last_i;
      end
      if (cmd_i.start_read) begin
        acc_q    <= 1'b0;
        done_q   <= 1'b0;
        push_q   <= msg_q;
        rd_hit_q <= r_new || rd_act_q;
        if (r_new) begin
          head_q   <= (32'(head_q) == RING_SLOTS - 1) ? '0 : head_q + 1'b1;
          rd_blk_q <= r_blk;
          rd_act_q <= 1'b1;
        end
        if (r_new || rd_act_q) rd_pos_q <= r_pos + 1'b1;
      end
      if (cmd_i.finish_read && rd_hit_q && rd_pos_q >= rd_len_q) begin
        rd_act_q <= 1'b0;
        rd_pos_q <= '0;
        if (32'(free_cnt_q) < POOL_BLOCKS) begin
          free_cnt_q <= free_cnt_q + 1'b1;
          free_wr_q[BlkW'(free_cnt_q)] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_o     <= 1'b0;
      read_byte_o    <= '0;
      read_valid_o   <= 1'b0;
      pushed_count_o <= '0;
      message_done_o <= 1'b0;
      free_blocks_o  <= '0;
    end else if (cmd_i.load_out) begin
      accepted_o     <= acc_q;
      read_byte_o    <= rd_hit_q ? rd_data_q : 8'h00;
      read_valid_o   <= rd_hit_q;
      pushed_count_o <= push_q;
      message_done_o <= done_q;
      free_blocks_o  <= free_cnt_q;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the chunk pool byte FIFO: predicts every result and checks it field by field.
`timescale 1ns / 1ps

module testbench;
  import rcp_pkg::*;

  localparam int Blocks = PoolBlocksDef;
  localparam int BlkBytes = BlockBytesDef;
  localparam int Slots = RingSlotsDef;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [15:0] pushed_count;
    logic        message_done;
    logic [5:0]  free_blocks;
  } fifo_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ActWrite;
  logic [7:0] write_byte_i = '0;
  logic message_last_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ChunkW-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o;
  logic [7:0] read_byte_o;
  logic read_valid_o;
  logic [15:0] pushed_count_o;
  logic message_done_o;
  logic [5:0] free_blocks_o;

  rx_chunk_pool_byte_fifo_unit uut (.*);

  // Mirror of the pool, the ring and the fill/read cursors.
  logic [7:0] pool_bytes [Blocks][BlkBytes];
  int block_len [Blocks];
  int free_list [Blocks];
  int free_num;
  int ready_idx [Slots];
  int head_ptr, tail_ptr;
  int rd_block, rd_pos, fill_block, fill_num, msg_count;
  bit rd_busy, fill_busy, discarding;
  logic [ChunkW-1:0] chunk_reg;

  fifo_result_t pending_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // A new hold request starts a long stretch of receiver stall.
  always @(negedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void release_block(int blk);
    if (free_num < Blocks) begin
      free_list[free_num] = blk;
      free_num++;
    end
  endfunction

  function automatic fifo_result_t pool_fifo_step(logic act, logic [7:0] wb, logic last);
    fifo_result_t r;
    int chunk_lim;
    r = '0;
    chunk_lim = (chunk_reg == 0 || chunk_reg > BlkBytes) ? BlkBytes : int'(chunk_reg);
    if (act == ActWrite) begin
      if (!discarding && !fill_busy) begin
        if (free_num == 0) begin
          discarding = 1'b1;
        end else begin
          free_num--;
          fill_block = free_list[free_num];
          fill_num = 0;
          fill_busy = 1'b1;
        end
      end
      if (!discarding && fill_busy) begin
        pool_bytes[fill_block][fill_num] = wb;
        fill_num++;
        r.accepted = 1'b1;
        if (fill_num >= chunk_lim || last) begin
          fill_busy = 1'b0;
          if ((tail_ptr + 1) % Slots != head_ptr) begin
            block_len[fill_block] = fill_num;
            ready_idx[tail_ptr] = fill_block;
            tail_ptr = (tail_ptr + 1) % Slots;
            msg_count += fill_num;
            if (msg_count > 65535) msg_count = 65535;
          end else begin
            release_block(fill_block);
            discarding = 1'b1;
          end
          fill_num = 0;
        end
      end
      r.pushed_count = 16'(msg_count);
      if (last) begin
        r.message_done = 1'b1;
        msg_count = 0;
        discarding = 1'b0;
      end
    end else begin
      if (!rd_busy && head_ptr != tail_ptr) begin
        rd_block = ready_idx[head_ptr];
        head_ptr = (head_ptr + 1) % Slots;
        rd_pos = 0;
        rd_busy = 1'b1;
      end
      if (rd_busy) begin
        r.read_byte = pool_bytes[rd_block][rd_pos];
        r.read_valid = 1'b1;
        rd_pos++;
        if (rd_pos >= block_len[rd_block]) begin
          release_block(rd_block);
          rd_busy = 1'b0;
          rd_pos = 0;
        end
      end
      r.pushed_count = 16'(msg_count);
    end
    r.free_blocks = 6'(free_num);
    return r;
  endfunction

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    fifo_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (accepted_o !== exp_r.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_r.accepted, accepted_o);
          error_count++;
        end
        if (read_byte_o !== exp_r.read_byte) begin
          $error("read_byte: expected %0h, got %0h", exp_r.read_byte, read_byte_o);
          error_count++;
        end
        if (read_valid_o !== exp_r.read_valid) begin
          $error("read_valid: expected %0d, got %0d", exp_r.read_valid, read_valid_o);
          error_count++;
        end
        if (pushed_count_o !== exp_r.pushed_count) begin
          $error("pushed_count: expected %0d, got %0d", exp_r.pushed_count, pushed_count_o);
          error_count++;
        end
        if (message_done_o !== exp_r.message_done) begin
          $error("message_done: expected %0d, got %0d", exp_r.message_done, message_done_o);
          error_count++;
        end
        if (free_blocks_o !== exp_r.free_blocks) begin
          $error("free_blocks: expected %0d, got %0d", exp_r.free_blocks, free_blocks_o);
          error_count++;
        end
      end
    end
  end

  // Sends one item; starts and ends at a falling edge.
  task automatic send_item(logic act, logic [7:0] wb, logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    write_byte_i <= wb;
    message_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(pool_fifo_step(act, wb, last));
    @(negedge clk_i);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_item(ActWrite, 8'($urandom_range(0, 255)), i == len - 1);
  endtask

  task automatic send_reads(int n);
    for (int i = 0; i < n; i++)
      send_item(ActRead, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_chunk_size(logic [ChunkW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    chunk_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(ActRead, 8'h00, 1'b0);
    send_item(ActWrite, 8'h00, 1'b0);
    send_item(ActWrite, 8'hFF, 1'b0);
    send_item(ActWrite, 8'hA5, 1'b1);
    send_reads(4);
    // A chunk holding more bytes than the new size completes on its next byte.
    send_item(ActWrite, 8'h5A, 1'b0);
    send_item(ActWrite, 8'h3C, 1'b0);
    send_item(ActWrite, 8'hC3, 1'b0);
    write_chunk_size(9'd2);
    send_item(ActWrite, 8'h81, 1'b0);
    send_item(ActWrite, 8'h7E, 1'b1);
    send_reads(6);
  endtask

  task automatic test_pool_and_ring_limits();
    // Ring full: single-byte chunks until the ring refuses one.
    write_chunk_size(9'd1);
    send_message(34);
    send_reads(33);
    // Pool empty: one block held by the reader, the ring full of the rest.
    write_chunk_size(9'd2);
    send_message(2);
    send_reads(1);
    send_message(66);
    send_reads(66);
  endtask

  task automatic test_random(int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 12);
      send_message(len);
      sent += len;
      len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(len / 2, len + 4);
      send_reads(len);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    send_message(20);
    send_reads(20);
  endtask

  initial begin
    chunk_reg = ChunkW'(BlkBytes);
    free_num = Blocks;
    for (int i = 0; i < Blocks; i++) free_list[i] = Blocks - 1 - i;
    head_ptr = 0; tail_ptr = 0;
    rd_block = 0; rd_pos = 0; rd_busy = 1'b0;
    fill_block = 0; fill_num = 0; fill_busy = 1'b0;
    discarding = 1'b0; msg_count = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_pool_and_ring_limits();
    test_backpressure();

    write_chunk_size(9'd4);
    test_random(300);
    write_chunk_size(9'd0);
    send_idle_pct = 53;
    test_random(300);
    write_chunk_size(9'd300);
    send_idle_pct = 0;
    stall_pct = 53;
    test_random(300);
    write_chunk_size(9'd511);
    send_idle_pct = 26;
    stall_pct = 26;
    test_random(300);
    write_chunk_size(ChunkW'($urandom_range(1, 16)));
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(300);

    wait_drained();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
